// ===== sv/nbns_pkg.sv =====
package nbns_pkg;

  // Buffer depth default
  parameter int MAX_PACKET = 1024;

  // Width of the length and offset arithmetic (sized for buffer depths that fit in 17 bits)
  parameter int WIDE_W = 17;

  typedef logic [1:0] verdict_t;

  parameter verdict_t V_INPROCESS = 2'd0;
  parameter verdict_t V_FOUND     = 2'd1;
  parameter verdict_t V_NOMATCH   = 2'd2;
  parameter verdict_t V_INCOMPAT  = 2'd3;

  // Name label layout
  parameter int LABEL_BYTES  = 34;
  parameter int NAME_LETTERS = 32;
  parameter int HEADER_BYTES = 12;
  parameter int MAX_RCODE    = 7;

  // Record types
  parameter logic [15:0] TYPE_NB     = 16'd32;
  parameter logic [15:0] TYPE_NBSTAT = 16'd33;

  // Name length flags
  parameter logic [1:0] FLAG_INLINE  = 2'b00;
  parameter logic [1:0] FLAG_POINTER = 2'b11;

endpackage

// ===== sv/nbns_ram.sv =====
module nbns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/nbns_packet_validator_core.sv =====
// Bytes load at one word per cycle while no parse is running and the output is free.
// Empty, short and oversize packets have their verdict valid in the cycle after the word.
// Otherwise the parser checks header bytes 2 and 3 and may decide there, or for a response it
// walks each record: name, its 34-byte label byte by byte, type and, in later sections, data.
// A stalled verdict holds the parser and the input; throughput is one packet at a time.
// Reset clears control state; the buffer is not cleared.
module nbns_packet_validator_core #(
  parameter int MaxPacket = nbns_pkg::MAX_PACKET
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           packet_byte_i,
  input  logic                 last_byte_i,
  input  logic                 empty_packet_i,
  input  logic                 from_responder_i,
  input  logic                 reversed_seen_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output nbns_pkg::verdict_t   verdict_o,
  output logic                 mark_reversed_o,
  output logic                 too_long_o
);

  localparam int AW = (MaxPacket > 1) ? $clog2(MaxPacket) : 1;
  localparam int CW = $clog2(MaxPacket + 1);
  localparam int WW = nbns_pkg::WIDE_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_H1     = 4'd1;
  localparam logic [3:0] S_H2     = 4'd2;
  localparam logic [3:0] S_CNT_HI = 4'd3;
  localparam logic [3:0] S_CNT_LO = 4'd4;
  localparam logic [3:0] S_REC    = 4'd5;
  localparam logic [3:0] S_NAME   = 4'd6;
  localparam logic [3:0] S_PTR    = 4'd7;
  localparam logic [3:0] S_LAB    = 4'd8;
  localparam logic [3:0] S_T_HI   = 4'd9;
  localparam logic [3:0] S_T_LO   = 4'd10;
  localparam logic [3:0] S_D_HI   = 4'd11;
  localparam logic [3:0] S_D_LO   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]         state_q, state_d;
  logic [CW-1:0]      byte_count_q, byte_count_d;
  logic               overflow_seen_q, overflow_seen_d;
  logic [CW-1:0]      n_q, n_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      lab_q, lab_d;
  logic [5:0]         k_q, k_d;
  logic [15:0]        cnt_q, cnt_d;
  logic [7:0]         hi_q, hi_d;
  logic [1:0]         sec_q, sec_d;
  logic               from_q, from_d;
  logic               rev_q, rev_d;
  nbns_pkg::verdict_t res_v_q, res_v_d;
  logic               res_m_q, res_m_d;
  logic               out_valid_q, out_valid_d;
  nbns_pkg::verdict_t verdict_q;
  logic               mark_q, too_long_q;

  logic               in_acc, out_free, count_full, ovf_now;
  logic [CW-1:0]      count_inc, n_new, rem;
  logic               we;
  logic [AW-1:0]      raddr;
  logic [7:0]         rdata;
  logic               res_load, res_m, res_t;
  nbns_pkg::verdict_t res_v;
  logic [3:0]         opcode;
  logic [15:0]        word;
  logic               lab_ok;

  nbns_ram #(
    .WIDTH (8),
    .DEPTH (MaxPacket)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(byte_count_q)),
    .wdata_i (packet_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Handshake
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) | (out_valid_q & out_stall_i);
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign count_full = WW'(byte_count_q) >= WW'(MaxPacket);
  assign count_inc  = byte_count_q + CW'(1);
  assign ovf_now    = overflow_seen_q | count_full;
  assign n_new      = count_full ? byte_count_q : count_inc;
  assign we         = in_acc & ~empty_packet_i & ~count_full;

  assign rem    = n_q - pos_q;
  assign opcode = hi_q[6:3];
  assign word   = {hi_q, rdata};

  // Check one label byte against its place in the label
  always_comb begin
    priority if (k_q == 6'd0) begin
      lab_ok = (rdata == 8'(nbns_pkg::NAME_LETTERS));
    end else if (k_q == 6'(nbns_pkg::LABEL_BYTES - 1)) begin
      lab_ok = (rdata == 8'd0);
    end else begin
      lab_ok = (rdata >= 8'h41) && (rdata <= 8'h5A);
    end
  end

  // Load bytes and step the parser
  always_comb begin
    state_d         = state_q;
    byte_count_d    = byte_count_q;
    overflow_seen_d = overflow_seen_q;
    n_d             = n_q;
    pos_d           = pos_q;
    lab_d           = lab_q;
    k_d             = k_q;
    cnt_d           = cnt_q;
    hi_d            = hi_q;
    sec_d           = sec_q;
    from_d          = from_q;
    rev_d           = rev_q;
    res_v_d         = res_v_q;
    res_m_d         = res_m_q;
    raddr           = '0;
    res_load        = 1'b0;
    res_v           = nbns_pkg::V_INPROCESS;
    res_m           = 1'b0;
    res_t           = 1'b0;

    if (in_acc) begin
      if (empty_packet_i) begin
        byte_count_d    = '0;
        overflow_seen_d = 1'b0;
        res_load        = 1'b1;
      end else begin
        if (count_full) begin
          overflow_seen_d = 1'b1;
        end else begin
          byte_count_d = count_inc;
        end
        if (last_byte_i) begin
          byte_count_d    = '0;
          overflow_seen_d = 1'b0;
          priority if (ovf_now) begin
            res_load = 1'b1;
            res_v    = nbns_pkg::V_NOMATCH;
            res_t    = 1'b1;
          end else if (WW'(n_new) < WW'(nbns_pkg::HEADER_BYTES)) begin
            res_load = 1'b1;
            res_v    = nbns_pkg::V_NOMATCH;
          end else begin
            n_d     = n_new;
            from_d  = from_responder_i;
            rev_d   = reversed_seen_i;
            raddr   = AW'(2);
            state_d = S_H1;
          end
        end
      end
    end

    unique case (state_q)
      S_IDLE: begin
      end
      S_H1: begin
        hi_d    = rdata;
        raddr   = AW'(3);
        state_d = S_H2;
      end
      // Header checks on bytes 2 and 3
      S_H2: begin
        state_d = S_DONE;
        res_m_d = 1'b0;
        priority if ((opcode >= 4'd1 && opcode <= 4'd4) ||
                     (opcode >= 4'd10 && opcode <= 4'd14)) begin
          res_v_d = nbns_pkg::V_NOMATCH;
        end else if (hi_q[1] || rdata[4]) begin
          res_v_d = nbns_pkg::V_INCOMPAT;
        end else if (!hi_q[7]) begin
          priority if (!from_q) begin
            res_v_d = nbns_pkg::V_INPROCESS;
          end else if (rev_q) begin
            res_v_d = nbns_pkg::V_FOUND;
          end else begin
            res_v_d = nbns_pkg::V_NOMATCH;
          end
        end else if (rdata[3:0] > 4'(nbns_pkg::MAX_RCODE)) begin
          res_v_d = nbns_pkg::V_NOMATCH;
        end else begin
          sec_d   = 2'd0;
          pos_d   = CW'(nbns_pkg::HEADER_BYTES);
          raddr   = AW'(4);
          state_d = S_CNT_HI;
        end
      end
      S_CNT_HI: begin
        hi_d    = rdata;
        raddr   = AW'(WW'(5) + (WW'(sec_q) << 1));
        state_d = S_CNT_LO;
      end
      S_CNT_LO: begin
        cnt_d   = word;
        state_d = S_REC;
      end
      // Next record, or next section
      S_REC: begin
        priority if (cnt_q == 16'd0) begin
          if (sec_q == 2'd3) begin
            state_d = S_DONE;
            res_v_d = from_q ? nbns_pkg::V_FOUND : nbns_pkg::V_INPROCESS;
            res_m_d = ~from_q;
          end else begin
            sec_d   = sec_q + 2'd1;
            raddr   = AW'(WW'(6) + (WW'(sec_q) << 1));
            state_d = S_CNT_HI;
          end
        end else if (pos_q >= n_q) begin
          state_d = S_DONE;
          res_v_d = nbns_pkg::V_NOMATCH;
          res_m_d = 1'b0;
        end else begin
          raddr   = AW'(pos_q);
          state_d = S_NAME;
        end
      end
      // Inline label or pointer
      S_NAME: begin
        res_v_d = nbns_pkg::V_NOMATCH;
        res_m_d = 1'b0;
        priority if (rdata[7:6] == nbns_pkg::FLAG_INLINE) begin
          if (WW'(rem) < WW'(nbns_pkg::LABEL_BYTES)) begin
            state_d = S_DONE;
          end else begin
            lab_d   = pos_q;
            pos_d   = CW'(WW'(pos_q) + WW'(nbns_pkg::LABEL_BYTES));
            k_d     = '0;
            raddr   = AW'(pos_q);
            state_d = S_LAB;
          end
        end else if (rdata[7:6] == nbns_pkg::FLAG_POINTER) begin
          if (WW'(rem) < WW'(2)) begin
            state_d = S_DONE;
          end else begin
            raddr   = AW'(WW'(pos_q) + WW'(1));
            pos_d   = CW'(WW'(pos_q) + WW'(2));
            state_d = S_PTR;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_PTR: begin
        if (WW'(rdata) + WW'(nbns_pkg::LABEL_BYTES) > WW'(n_q)) begin
          state_d = S_DONE;
          res_v_d = nbns_pkg::V_NOMATCH;
          res_m_d = 1'b0;
        end else begin
          lab_d   = CW'(rdata);
          k_d     = '0;
          raddr   = AW'(rdata);
          state_d = S_LAB;
        end
      end
      // Walk the label, then fetch the type
      S_LAB: begin
        priority if (!lab_ok) begin
          state_d = S_DONE;
          res_v_d = nbns_pkg::V_NOMATCH;
          res_m_d = 1'b0;
        end else if (k_q != 6'(nbns_pkg::LABEL_BYTES - 1)) begin
          k_d   = k_q + 6'd1;
          raddr = AW'(WW'(lab_q) + WW'(k_q) + WW'(1));
        end else if (WW'(rem) < WW'(4)) begin
          state_d = S_DONE;
          res_v_d = nbns_pkg::V_NOMATCH;
          res_m_d = 1'b0;
        end else begin
          raddr   = AW'(pos_q);
          state_d = S_T_HI;
        end
      end
      S_T_HI: begin
        hi_d    = rdata;
        raddr   = AW'(WW'(pos_q) + WW'(1));
        state_d = S_T_LO;
      end
      S_T_LO: begin
        pos_d = CW'(WW'(pos_q) + WW'(4));
        priority if (word != nbns_pkg::TYPE_NB && word != nbns_pkg::TYPE_NBSTAT) begin
          state_d = S_DONE;
          res_v_d = nbns_pkg::V_NOMATCH;
          res_m_d = 1'b0;
        end else if (sec_q == 2'd0) begin
          cnt_d   = cnt_q - 16'd1;
          state_d = S_REC;
        end else if (WW'(rem) < WW'(10)) begin
          state_d = S_DONE;
          res_v_d = nbns_pkg::V_NOMATCH;
          res_m_d = 1'b0;
        end else begin
          raddr   = AW'(WW'(pos_q) + WW'(8));
          state_d = S_D_HI;
        end
      end
      S_D_HI: begin
        hi_d    = rdata;
        raddr   = AW'(WW'(pos_q) + WW'(5));
        state_d = S_D_LO;
      end
      // Skip the record data
      S_D_LO: begin
        if (WW'(word) > WW'(rem) - WW'(6)) begin
          state_d = S_DONE;
          res_v_d = nbns_pkg::V_NOMATCH;
          res_m_d = 1'b0;
        end else begin
          pos_d   = CW'(WW'(pos_q) + WW'(6) + WW'(word));
          cnt_d   = cnt_q - 16'd1;
          state_d = S_REC;
        end
      end
      // Hold the verdict until the output register frees
      S_DONE: begin
        if (out_free) begin
          res_load = 1'b1;
          res_v    = res_v_q;
          res_m    = res_m_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      byte_count_q    <= '0;
      overflow_seen_q <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      byte_count_q    <= byte_count_d;
      overflow_seen_q <= overflow_seen_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    pos_q   <= pos_d;
    lab_q   <= lab_d;
    k_q     <= k_d;
    cnt_q   <= cnt_d;
    hi_q    <= hi_d;
    sec_q   <= sec_d;
    from_q  <= from_d;
    rev_q   <= rev_d;
    res_v_q <= res_v_d;
    res_m_q <= res_m_d;
    if (res_load) begin
      verdict_q  <= res_v;
      mark_q     <= res_m;
      too_long_q <= res_t;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign verdict_o       = verdict_q;
  assign mark_reversed_o = mark_q;
  assign too_long_o      = too_long_q;

  // Checks
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("word taken while parsing");

  a_too_long_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_long_o) |-> (verdict_o == nbns_pkg::V_NOMATCH))
    else $error("too_long without no match");

  a_mark_inprocess: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mark_reversed_o) |-> (verdict_o == nbns_pkg::V_INPROCESS && !too_long_o))
    else $error("mark_reversed with wrong verdict");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(byte_count_q) <= WW'(MaxPacket))
    else $error("byte count past buffer");

  a_done_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_free) |=> (state_q == S_DONE))
    else $error("verdict dropped");

endmodule
